>>> rtl/perceptron_branch_predictor_macros.svh
// assertion helpers used by the checker file
`ifndef PERCEPTRON_BRANCH_PREDICTOR_MACROS_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_MACROS_SVH

// same-cycle implication
`define PBP_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbp assertion failed");

// next-cycle implication
`define PBP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbp assertion failed");

`endif

>>> rtl/pbp_pkg.sv
package pbp_pkg;

    localparam int NUM_ROWS_DEF    = 248;
    localparam int HISTORY_LEN_DEF = 32;
    localparam int WEIGHT_BITS_DEF = 8;

    localparam int ADDR_W = 32;
    localparam int THR_W  = 13;
    localparam int SUM_W  = 14;

    localparam logic [THR_W-1:0] THR_RESET = 13'd75;
    localparam int SUM_MAX = 8191;
    localparam int SUM_MIN = -8192;

    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_TRAIN   = 1'b1;

    typedef struct packed {
        logic capture;
        logic qmul;
        logic rem;
        logic rd_en;
        logic sum_part;
        logic sum_total;
        logic train_wr;
        logic load_rsp;
        logic clr_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic is_train;
        logic clr_last;
    } t_dp_status;

endpackage

>>> rtl/pbp_req_if.sv
interface pbp_req_if import pbp_pkg::*;;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [ADDR_W-1:0] branch_address;
    logic              branch_taken;

    modport source(output valid, mode, branch_address, branch_taken, input ready);
    modport sink(input valid, mode, branch_address, branch_taken, output ready);
endinterface

>>> rtl/pbp_rsp_if.sv
interface pbp_rsp_if import pbp_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    predict_taken;
    logic signed [SUM_W-1:0] perceptron_sum;
    logic                    weights_updated;

    modport source(output valid, predict_taken, perceptron_sum, weights_updated, input ready);
    modport sink(input valid, predict_taken, perceptron_sum, weights_updated, output ready);
endinterface

>>> rtl/perceptron_branch_predictor.sv
// Perceptron branch predictor with one weight row per table entry, row picked by
// branch address modulo NUM_ROWS. After reset the block zeroes the weight table,
// one row per cycle, and takes no item until that is done; the threshold register
// can be written at any time. Items are handled one at a time: each passes through
// the row index reduction (a reciprocal multiply, a multiply back and a correction),
// the registered row read, and then the two-level adder tree for predict or the row
// rewrite for train, before the next item can be taken. A result left waiting only
// delays the next one; the next item is still accepted while it waits.
module perceptron_branch_predictor import pbp_pkg::*; #(
    parameter int NUM_ROWS    = NUM_ROWS_DEF,
    parameter int HISTORY_LEN = HISTORY_LEN_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pbp_req_if.sink          i_req,
    pbp_rsp_if.source        o_rsp,
    input  logic             i_cfg_wr_en,
    input  logic [THR_W-1:0] i_cfg_wr_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    pbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req.valid),
        .o_req_ready(i_req.ready),
        .o_rsp_valid(o_rsp.valid),
        .i_rsp_ready(o_rsp.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pbp_dp #(
        .NUM_ROWS   (NUM_ROWS),
        .HISTORY_LEN(HISTORY_LEN),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_wr_data        (i_cfg_wr_data),
        .i_req_mode           (i_req.mode),
        .i_req_addr           (i_req.branch_address),
        .i_req_taken          (i_req.branch_taken),
        .o_rsp_predict_taken  (o_rsp.predict_taken),
        .o_rsp_perceptron_sum (o_rsp.perceptron_sum),
        .o_rsp_weights_updated(o_rsp.weights_updated)
    );

endmodule

>>> rtl/pbp_ram.sv
module pbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pbp_ctrl.sv
module pbp_ctrl import pbp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    output logic       o_rsp_valid,
    input  logic       i_rsp_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_QMUL,
        S_REM,
        S_READ,
        S_SUM,
        S_TOTAL,
        S_UPD,
        S_LOAD
    } t_state;

    t_state r_state;
    logic   r_req_ready;
    logic   r_rsp_valid;
    logic   accept;
    logic   load_ok;

    assign accept  = i_req_valid && r_req_ready;
    assign load_ok = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = (r_state == S_IDLE) && accept;
        o_cmd.qmul      = (r_state == S_QMUL);
        o_cmd.rem       = (r_state == S_REM);
        o_cmd.rd_en     = (r_state == S_READ);
        o_cmd.sum_part  = (r_state == S_SUM);
        o_cmd.sum_total = (r_state == S_TOTAL);
        o_cmd.train_wr  = (r_state == S_UPD);
        o_cmd.load_rsp  = (r_state == S_LOAD) && load_ok;
        o_cmd.clr_wr    = (r_state == S_CLEAR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_req_ready <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (r_rsp_valid && i_rsp_ready && !o_cmd.load_rsp) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (i_status.clr_last) begin
                        r_state     <= S_IDLE;
                        r_req_ready <= 1'b1;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state     <= S_QMUL;
                        r_req_ready <= 1'b0;
                    end
                end
                S_QMUL: r_state <= S_REM;
                S_REM:  r_state <= S_READ;
                S_READ: begin
                    r_state <= i_status.is_train ? S_UPD : S_SUM;
                end
                S_SUM:   r_state <= S_TOTAL;
                S_TOTAL: r_state <= S_LOAD;
                S_UPD:   r_state <= S_LOAD;
                S_LOAD: begin
                    if (load_ok) begin
                        r_rsp_valid <= 1'b1;
                        r_req_ready <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_req_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_req_ready = r_req_ready;
    assign o_rsp_valid = r_rsp_valid;

endmodule

>>> rtl/pbp_dp.sv
module pbp_dp import pbp_pkg::*; #(
    parameter int NUM_ROWS    = NUM_ROWS_DEF,
    parameter int HISTORY_LEN = HISTORY_LEN_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    input  logic                    i_cfg_wr_en,
    input  logic [THR_W-1:0]        i_cfg_wr_data,
    input  logic                    i_req_mode,
    input  logic [ADDR_W-1:0]       i_req_addr,
    input  logic                    i_req_taken,
    output logic                    o_rsp_predict_taken,
    output logic signed [SUM_W-1:0] o_rsp_perceptron_sum,
    output logic                    o_rsp_weights_updated
);

    localparam int ROW_LEN = HISTORY_LEN + 1;
    localparam int ROW_W   = ROW_LEN * WEIGHT_BITS;
    localparam int ROW_AW  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int GRP     = 8;
    localparam int NGRP    = (ROW_LEN + GRP - 1) / GRP;
    localparam int PAD_LEN = NGRP * GRP;
    localparam int TERM_W  = WEIGHT_BITS + 1;
    localparam int PART_W  = TERM_W + $clog2(GRP);
    localparam int TOT_RAW = PART_W + $clog2(NGRP) + 1;
    localparam int TOT_W   = (TOT_RAW > SUM_W) ? TOT_RAW : SUM_W + 1;
    localparam int REM_W   = $clog2(3 * NUM_ROWS) + 1;

    localparam logic [ADDR_W-1:0] RECIP   = ADDR_W'(64'h0000_0000_FFFF_FFFF / NUM_ROWS);
    localparam logic [ADDR_W-1:0] NROWS_A = ADDR_W'(NUM_ROWS);
    localparam logic [REM_W-1:0]  N1_R    = REM_W'(NUM_ROWS);
    localparam logic [REM_W-1:0]  N2_R    = REM_W'(2 * NUM_ROWS);
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(NUM_ROWS - 1);

    localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
    localparam logic signed [TOT_W-1:0] T_MAX = TOT_W'(SUM_MAX);
    localparam logic signed [TOT_W-1:0] T_MIN = TOT_W'(SUM_MIN);

    logic                    r_mode;
    logic                    r_taken;
    logic [ADDR_W-1:0]       r_addr;
    logic [2*ADDR_W-1:0]     r_prod;
    logic [ADDR_W-1:0]       r_qn;
    logic [ROW_AW-1:0]       r_row;
    logic [ROW_AW-1:0]       r_clr_cnt;
    logic [HISTORY_LEN-1:0]  r_hist;
    logic [THR_W-1:0]        r_thr;
    logic signed [SUM_W-1:0] r_last_sum;
    logic                    r_last_pred;
    logic                    r_updated;
    logic signed [PART_W-1:0] r_part [NGRP];
    logic                    r_rsp_pred;
    logic signed [SUM_W-1:0] r_rsp_sum;
    logic                    r_rsp_upd;

    logic [ROW_W-1:0]        rdata;
    logic [ROW_W-1:0]        n_row;
    logic [ROW_LEN-1:0]      hist_ext;
    logic [PAD_LEN*WEIGHT_BITS-1:0] row_pad;
    logic [PAD_LEN-1:0]      hist_pad;
    logic signed [PART_W-1:0] n_part [NGRP];
    logic signed [TOT_W-1:0] total;
    logic signed [SUM_W-1:0] n_sum;
    logic [ADDR_W-1:0]       diff;
    logic [REM_W-1:0]        rem;
    logic [REM_W-1:0]        n_rem;
    logic [SUM_W-1:0]        mag;
    logic                    do_upd;
    logic                    ram_we;
    logic [ROW_AW-1:0]       ram_waddr;
    logic [ROW_W-1:0]        ram_wdata;

    // bit 0 pairs with the bias, which always counts positive
    assign hist_ext = {r_hist, 1'b1};
    assign row_pad  = (PAD_LEN*WEIGHT_BITS)'(rdata);
    assign hist_pad = PAD_LEN'(hist_ext);

    // row index: reciprocal quotient estimate, remainder below three row counts
    assign diff = r_addr - r_qn;
    assign rem  = diff[REM_W-1:0];
    always_comb begin
        if (rem >= N2_R) begin
            n_rem = rem - N2_R;
        end else if (rem >= N1_R) begin
            n_rem = rem - N1_R;
        end else begin
            n_rem = rem;
        end
    end

    always_comb begin
        logic signed [TERM_W-1:0] term;
        logic signed [PART_W-1:0] acc;
        for (int g = 0; g < NGRP; g++) begin
            acc = '0;
            for (int k = 0; k < GRP; k++) begin
                term = TERM_W'(signed'(row_pad[(g*GRP+k)*WEIGHT_BITS +: WEIGHT_BITS]));
                if (hist_pad[g*GRP+k]) begin
                    acc = acc + PART_W'(term);
                end else begin
                    acc = acc - PART_W'(term);
                end
            end
            n_part[g] = acc;
        end
    end

    always_comb begin
        total = '0;
        for (int g = 0; g < NGRP; g++) begin
            total = total + TOT_W'(r_part[g]);
        end
        if (total > T_MAX) begin
            n_sum = SUM_W'(T_MAX);
        end else if (total < T_MIN) begin
            n_sum = SUM_W'(T_MIN);
        end else begin
            n_sum = SUM_W'(total);
        end
    end

    always_comb begin
        logic signed [WEIGHT_BITS-1:0] w;
        for (int j = 0; j < ROW_LEN; j++) begin
            w = signed'(rdata[j*WEIGHT_BITS +: WEIGHT_BITS]);
            if (hist_ext[j] == r_taken) begin
                n_row[j*WEIGHT_BITS +: WEIGHT_BITS] = (w == W_MAX) ? w : w + 2'sd1;
            end else begin
                n_row[j*WEIGHT_BITS +: WEIGHT_BITS] = (w == W_MIN) ? w : w - 2'sd1;
            end
        end
    end

    assign mag    = r_last_sum[SUM_W-1] ? SUM_W'(-r_last_sum) : SUM_W'(r_last_sum);
    assign do_upd = (r_last_pred != r_taken) || (mag <= SUM_W'(r_thr));

    assign ram_we    = i_cmd.clr_wr || (i_cmd.train_wr && do_upd);
    assign ram_waddr = i_cmd.clr_wr ? r_clr_cnt : r_row;
    assign ram_wdata = i_cmd.clr_wr ? '0 : n_row;

    pbp_ram #(
        .WIDTH(ROW_W),
        .DEPTH(NUM_ROWS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.rd_en),
        .i_raddr(r_row),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_hist      <= '0;
            r_thr       <= THR_RESET;
            r_last_sum  <= '0;
            r_last_pred <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.sum_total) begin
                r_last_sum  <= n_sum;
                r_last_pred <= !n_sum[SUM_W-1];
            end
            if (i_cmd.train_wr) begin
                r_hist <= HISTORY_LEN'({r_hist, r_taken});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode    <= i_req_mode;
            r_taken   <= i_req_taken;
            r_addr    <= i_req_addr;
            r_prod    <= i_req_addr * RECIP;
            r_updated <= 1'b0;
        end
        if (i_cmd.qmul) begin
            r_qn <= r_prod[2*ADDR_W-1:ADDR_W] * NROWS_A;
        end
        if (i_cmd.rem) begin
            r_row <= ROW_AW'(n_rem);
        end
        if (i_cmd.sum_part) begin
            r_part <= n_part;
        end
        if (i_cmd.train_wr) begin
            r_updated <= do_upd;
        end
        if (i_cmd.load_rsp) begin
            r_rsp_pred <= r_last_pred;
            r_rsp_sum  <= r_last_sum;
            r_rsp_upd  <= r_updated;
        end
    end

    assign o_status.is_train = (r_mode == MODE_TRAIN);
    assign o_status.clr_last = (r_clr_cnt == LAST_ROW);

    assign o_rsp_predict_taken   = r_rsp_pred;
    assign o_rsp_perceptron_sum  = r_rsp_sum;
    assign o_rsp_weights_updated = r_rsp_upd;

endmodule

>>> rtl/pbp_checker.sv
`include "perceptron_branch_predictor_macros.svh"

module pbp_checker import pbp_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_req_valid,
    input logic                    i_req_ready,
    input logic                    i_rsp_valid,
    input logic                    i_rsp_ready,
    input logic                    i_rsp_predict_taken,
    input logic signed [SUM_W-1:0] i_rsp_perceptron_sum,
    input logic                    i_rsp_weights_updated
);

    // a negative sum never comes with a taken prediction
    `PBP_ASSERT_IMPL(a_sign_pred, i_clk, i_rst_n, i_rsp_valid && i_rsp_perceptron_sum[SUM_W-1], !i_rsp_predict_taken)

    // one item at a time
    `PBP_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // a result only shows up after the block was busy
    `PBP_ASSERT_IMPL(a_rsp_after_busy, i_clk, i_rst_n, $rose(i_rsp_valid), !$past(i_req_ready))

    // stalled result holds
    `PBP_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_predict_taken) && $stable(i_rsp_perceptron_sum) && $stable(i_rsp_weights_updated))

endmodule

bind perceptron_branch_predictor pbp_checker u_pbp_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_req_valid          (i_req.valid),
    .i_req_ready          (i_req.ready),
    .i_rsp_valid          (o_rsp.valid),
    .i_rsp_ready          (o_rsp.ready),
    .i_rsp_predict_taken  (o_rsp.predict_taken),
    .i_rsp_perceptron_sum (o_rsp.perceptron_sum),
    .i_rsp_weights_updated(o_rsp.weights_updated)
);

>>> tb/tb_perceptron_branch_predictor.sv
module tb_perceptron_branch_predictor;
    import pbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS = NUM_ROWS_DEF;
    localparam int HLEN = HISTORY_LEN_DEF;
    localparam int WBITS = WEIGHT_BITS_DEF;
    localparam int W_HI = 2 ** (WBITS - 1) - 1;
    localparam int W_LO = -(2 ** (WBITS - 1));

    typedef struct {
        logic                    predict_taken;
        logic signed [SUM_W-1:0] perceptron_sum;
        logic                    weights_updated;
    } t_verdict;

    typedef enum {OUTCOME_RANDOM, OUTCOME_SWING, OUTCOME_TAKEN} t_outcome_style;

    class perceptron_shadow;
        logic signed [WBITS-1:0] weights [ROWS][HLEN+1];
        logic [HLEN-1:0]         history;
        logic signed [SUM_W-1:0] last_sum;
        logic                    last_taken;
        logic [THR_W-1:0]        threshold;
        t_verdict                verdicts_due [$];
        int                      faults;

        function new();
            int r;
            int i;
            for (r = 0; r < ROWS; r++) begin
                for (i = 0; i <= HLEN; i++) begin
                    weights[r][i] = '0;
                end
            end
            history = '0;
            last_sum = '0;
            last_taken = 1'b0;
            threshold = THR_RESET;
            faults = 0;
        endfunction

        function logic signed [WBITS-1:0] nudge(logic signed [WBITS-1:0] w, logic up);
            int r;
            r = int'(w) + (up ? 1 : -1);
            if (r > W_HI) r = W_HI;
            if (r < W_LO) r = W_LO;
            return r[WBITS-1:0];
        endfunction

        function void absorb(logic mode, logic [ADDR_W-1:0] addr, logic taken);
            int row;
            int acc;
            int mag;
            int i;
            t_verdict v;
            row = int'(addr % ROWS);
            v.weights_updated = 1'b0;
            if (mode == MODE_PREDICT) begin
                acc = int'(weights[row][0]);
                for (i = 1; i <= HLEN; i++) begin
                    if (history[i-1]) acc += int'(weights[row][i]);
                    else acc -= int'(weights[row][i]);
                end
                if (acc > SUM_MAX) acc = SUM_MAX;
                if (acc < SUM_MIN) acc = SUM_MIN;
                last_sum = acc[SUM_W-1:0];
                last_taken = (acc >= 0);
            end else begin
                mag = (last_sum < 0) ? -int'(last_sum) : int'(last_sum);
                if (last_taken != taken || mag <= int'(threshold)) begin
                    weights[row][0] = nudge(weights[row][0], taken);
                    for (i = 1; i <= HLEN; i++) begin
                        weights[row][i] = nudge(weights[row][i], history[i-1] == taken);
                    end
                    v.weights_updated = 1'b1;
                end
                history = {history[HLEN-2:0], taken};
            end
            v.predict_taken = last_taken;
            v.perceptron_sum = last_sum;
            verdicts_due.push_back(v);
        endfunction

        function void compare(logic pt, logic signed [SUM_W-1:0] ps, logic wu);
            t_verdict want;
            if (verdicts_due.size() == 0) begin
                faults++;
                $display("%0t: unexpected result taken %0b sum %0d updated %0b",
                         $time, pt, ps, wu);
                return;
            end
            want = verdicts_due.pop_front();
            if (pt !== want.predict_taken) begin
                faults++;
                $display("%0t: predict_taken expected %0b actual %0b",
                         $time, want.predict_taken, pt);
            end
            if (ps !== want.perceptron_sum) begin
                faults++;
                $display("%0t: perceptron_sum expected %0d actual %0d",
                         $time, want.perceptron_sum, ps);
            end
            if (wu !== want.weights_updated) begin
                faults++;
                $display("%0t: weights_updated expected %0b actual %0b",
                         $time, want.weights_updated, wu);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [THR_W-1:0] i_cfg_wr_data;

    pbp_req_if req_if();
    pbp_rsp_if rsp_if();

    perceptron_branch_predictor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_if),
        .o_rsp         (rsp_if),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    perceptron_shadow  shadow;
    int                gap_pct;
    int                stall_pct;
    logic              swing_bit;
    logic [ADDR_W-1:0] hot_addr;
    logic [ADDR_W-1:0] addr_sheet [8];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_perceptron_branch_predictor: errors");
        $finish;
    end

    // result side back-pressure
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
                shadow.absorb(req_if.mode, req_if.branch_address, req_if.branch_taken);
            end
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                shadow.compare(rsp_if.predict_taken, rsp_if.perceptron_sum,
                               rsp_if.weights_updated);
            end
        end
    end

    task automatic send_item(input logic mode, input logic [ADDR_W-1:0] addr,
                             input logic taken);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode <= mode;
        req_if.branch_address <= addr;
        req_if.branch_taken <= taken;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        // let the monitor note the last accepted item first
        @(posedge i_clk);
        while (shadow.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_train_threshold(input logic [THR_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        shadow.threshold = value;
    endtask

    function automatic logic [ADDR_W-1:0] pick_address(input int hot_pct);
        if ($urandom_range(0, 99) < hot_pct) begin
            // the hot address or another one that aliases onto the same row
            return hot_addr + ROWS * $urandom_range(0, 3);
        end
        if ($urandom_range(0, 1) == 1) return addr_sheet[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic next_outcome(input t_outcome_style style);
        case (style)
            OUTCOME_SWING: begin
                swing_bit = ~swing_bit;
                if ($urandom_range(0, 99) < 4) swing_bit = ~swing_bit;
                return swing_bit;
            end
            OUTCOME_TAKEN: begin
                return ($urandom_range(0, 99) >= 3);
            end
            default: begin
                return 1'($urandom_range(0, 1));
            end
        endcase
    endfunction

    task automatic run_phase(input logic [THR_W-1:0] thr, input int count, input int hot_pct,
                             input int lone_train_pct, input int lone_predict_pct,
                             input t_outcome_style style);
        int sent;
        int pick;
        logic [ADDR_W-1:0] addr;
        sent = 0;
        set_train_threshold(thr);
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            addr = pick_address(hot_pct);
            if (pick < lone_train_pct) begin
                send_item(MODE_TRAIN, addr, next_outcome(style));
                sent += 1;
            end else if (pick < lone_train_pct + lone_predict_pct) begin
                send_item(MODE_PREDICT, addr, 1'($urandom_range(0, 1)));
                sent += 1;
            end else begin
                send_item(MODE_PREDICT, addr, 1'($urandom_range(0, 1)));
                // occasionally train a different branch than the one predicted
                if ($urandom_range(0, 9) == 0) addr = pick_address(hot_pct);
                send_item(MODE_TRAIN, addr, next_outcome(style));
                sent += 2;
            end
        end
        settle();
    endtask

    initial begin
        int k;
        shadow = new();
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        req_if.valid = 1'b0;
        req_if.mode = MODE_PREDICT;
        req_if.branch_address = '0;
        req_if.branch_taken = 1'b0;
        gap_pct = 20;
        stall_pct = 20;
        swing_bit = 1'b0;
        hot_addr = $urandom;
        for (k = 0; k < 8; k++) begin
            addr_sheet[k] = (k < 4) ? $urandom : addr_sheet[k-4] + ROWS;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items under the reset threshold
        send_item(MODE_TRAIN, 32'hFFFF_FFFF, 1'b1);
        send_item(MODE_PREDICT, 32'hFFFF_FFFF, 1'b0);
        send_item(MODE_TRAIN, 32'hFFFF_FFFF, 1'b0);
        send_item(MODE_PREDICT, 32'h0000_0000, 1'b0);
        send_item(MODE_TRAIN, 32'h0000_0000, 1'b1);
        send_item(MODE_PREDICT, 32'd248, 1'b1);
        send_item(MODE_TRAIN, 32'd248, 1'b1);
        send_item(MODE_PREDICT, 32'd247, 1'b0);
        send_item(MODE_PREDICT, 32'h8000_0000, 1'b1);
        send_item(MODE_TRAIN, 32'h8000_0000, 1'b0);
        send_item(MODE_TRAIN, 32'h8000_0000, 1'b0);
        send_item(MODE_PREDICT, 32'h7FFF_FFFF, 1'b1);
        send_item(MODE_TRAIN, 32'h7FFF_FFFF, 1'b1);
        send_item(MODE_PREDICT, 32'h5555_5555, 1'b0);
        send_item(MODE_TRAIN, 32'h5555_5555, 1'b0);
        send_item(MODE_PREDICT, 32'hAAAA_AAAA, 1'b1);
        send_item(MODE_TRAIN, 32'hAAAA_AAAA, 1'b1);
        send_item(MODE_PREDICT, 32'hAAAA_AAAA, 1'b0);
        settle();

        // alternating outcomes drive history weights to both limits
        gap_pct = 10;
        stall_pct = 10;
        run_phase(13'h1FFF, 240, 95, 70, 5, OUTCOME_SWING);
        // steady taken pushes the bias up and pulls weights off the low limit
        gap_pct = 25;
        stall_pct = 5;
        run_phase(13'd4224, 200, 95, 70, 5, OUTCOME_TAKEN);
        gap_pct = 5;
        stall_pct = 30;
        run_phase(13'd0, 100, 30, 10, 10, OUTCOME_RANDOM);
        gap_pct = 15;
        stall_pct = 15;
        run_phase(13'($urandom_range(0, 8191)), 100, 40, 15, 10, OUTCOME_RANDOM);
        gap_pct = 0;
        stall_pct = 0;
        run_phase(THR_RESET, 80, 40, 15, 10, OUTCOME_RANDOM);

        if (shadow.faults == 0 && shadow.verdicts_due.size() == 0) begin
            $display("tb_perceptron_branch_predictor: clean");
        end else begin
            $display("tb_perceptron_branch_predictor: errors");
        end
        $finish;
    end

endmodule
